@@ sv/advertising_service_uuid_finder_top_assert.svh @@
// assertion macros for the advertising service uuid finder
`ifndef ADVERTISING_SERVICE_UUID_FINDER_TOP_ASSERT_SVH
`define ADVERTISING_SERVICE_UUID_FINDER_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define AUF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AUF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/auf_pkg.sv @@
`timescale 1ns / 1ps

package auf_pkg;

    localparam int unsigned UUID_BYTES = 16;
    localparam int unsigned UUID_W     = 8 * UUID_BYTES;
    localparam int unsigned CFG_W      = 64;
    localparam int unsigned ADDR_W     = 4;

    localparam logic [7:0] TYPE_PARTIAL_128  = 8'h06;
    localparam logic [7:0] TYPE_COMPLETE_128 = 8'h07;

    // register select bit of paddr
    localparam logic REG_UUID_LOW  = 1'b0;
    localparam logic REG_UUID_HIGH = 1'b1;

    typedef enum logic [1:0] {
        PH_LENGTH = 2'd0,
        PH_TYPE   = 2'd1,
        PH_DATA   = 2'd2
    } auf_phase_t;

    typedef struct packed {
        logic done;
        logic found;
    } auf_result_t;

endpackage

@@ sv/advertising_service_uuid_finder_top.sv @@
`timescale 1ns / 1ps
// channel  | handshake                  | payload
// ---------+----------------------------+-------------------------
// in       | in_valid / in_stall        | ad_byte[7:0], last_byte
// out      | out_valid / out_stall      | service_found
// cfg      | psel penable pwrite pready | paddr[3:0], pwdata[63:0]
//
// one word a cycle sustained unless a last word waits on a stalled result; an input register
// feeds the byte parser, the result register holds the verdict of each payload
// a last word moves from input register to result register, held while a result is stalled
// rst_n is asynchronous, clears parse state, uuid registers and both valids
// in_stall rises only when a last word waits and the pending result is stalled
// uuid registers at byte address 0 (bytes 0..7) and 8 (bytes 8..15)

module advertising_service_uuid_finder_top
    import auf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input words
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        ad_byte,
    input  logic              last_byte,
    // results
    output logic              out_valid,
    input  logic              out_stall,
    output logic              service_found,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready
);

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic        found_reg;

    logic              blocked;
    logic              advance;
    logic              result_taken;
    logic [UUID_W-1:0] uuid;
    auf_result_t       result;

    auf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .uuid    (uuid)
    );

    // a last word may only move on when the result register can take it
    assign blocked  = in_last_reg && out_valid_reg && out_stall;
    assign advance  = in_valid_reg && !blocked;
    assign in_stall = in_valid_reg && blocked;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= ad_byte;
            in_last_reg <= last_byte;
        end
    end

    auf_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .ad_byte   (in_byte_reg),
        .last_byte (in_last_reg),
        .uuid      (uuid),
        .result    (result)
    );

    // hold while stalled, drop once taken, reload on a finished payload
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (result.done)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (result.done)
            found_reg <= result.found;
    end

    assign out_valid     = out_valid_reg;
    assign service_found = found_reg;

    // result word leaves at this edge
    assign result_taken = out_valid_reg && !out_stall;

`include "advertising_service_uuid_finder_top_assert.svh"

    `AUF_ASSERT_NEXT(a_last_gives_result, advance && in_last_reg, out_valid_reg, "last word lost")
    `AUF_ASSERT_SAME(a_stall_when_blocked, in_stall, out_valid_reg && out_stall, "stray stall")
    `AUF_ASSERT_NEXT(a_taken_clears, result_taken && !result.done, !out_valid_reg, "repeat")

endmodule

@@ sv/auf_cfg.sv @@
`timescale 1ns / 1ps

module auf_cfg
    import auf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [CFG_W-1:0]          pwdata,
    output logic [CFG_W-1:0]          prdata,
    output logic                      pready,
    output logic [UUID_W-1:0]         uuid
);

    logic [CFG_W-1:0] uuid_low_reg;
    logic [CFG_W-1:0] uuid_high_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // byte lanes below the register select are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uuid_low_reg  <= '0;
            uuid_high_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3])
                REG_UUID_LOW:  uuid_low_reg  <= pwdata;
                REG_UUID_HIGH: uuid_high_reg <= pwdata;
                default:       uuid_low_reg  <= uuid_low_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3])
            REG_UUID_LOW:  prdata = uuid_low_reg;
            REG_UUID_HIGH: prdata = uuid_high_reg;
            default:       prdata = '0;
        endcase
    end

    assign uuid = {uuid_high_reg, uuid_low_reg};

    // low address bits are not decoded
    logic unused_addr;
    assign unused_addr = ^paddr[2:0];

endmodule

@@ sv/auf_parse.sv @@
`timescale 1ns / 1ps

module auf_parse
    import auf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        ad_byte,
    input  logic              last_byte,
    input  logic [UUID_W-1:0] uuid,
    output auf_result_t       result
);

    auf_phase_t phase_reg, phase_next;
    logic [7:0] left_reg, left_next;
    logic [4:0] pos_reg, pos_next;
    logic       matching_reg, matching_next;
    logic       latched_reg, latched_next;

    logic [7:0] left_dec;
    logic [7:0] expect_byte;
    logic       type_hit;
    logic       cmp_active;
    logic       byte_ok;

    assign left_dec    = left_reg - 8'd1;
    assign expect_byte = uuid[{pos_reg[3:0], 3'b000} +: 8];
    assign type_hit    = (ad_byte == TYPE_PARTIAL_128) || (ad_byte == TYPE_COMPLETE_128);
    assign cmp_active  = matching_reg && (pos_reg < 5'(UUID_BYTES));
    assign byte_ok     = matching_reg && (ad_byte == expect_byte);

    // phase sequencing
    always_comb
    begin
        unique case (phase_reg)
            PH_TYPE:
                phase_next = (left_dec == 8'd0) ? PH_LENGTH : PH_DATA;
            PH_DATA:
                phase_next = (left_dec == 8'd0) ? PH_LENGTH : PH_DATA;
            default:
                phase_next = (ad_byte == 8'd0) ? PH_LENGTH : PH_TYPE;
        endcase
    end

    // counters and match tracking
    always_comb
    begin
        left_next     = left_reg;
        pos_next      = pos_reg;
        matching_next = matching_reg;
        latched_next  = latched_reg;
        unique case (phase_reg)
            PH_TYPE:
            begin
                left_next     = left_dec;
                pos_next      = '0;
                matching_next = type_hit && (left_dec >= 8'(UUID_BYTES));
            end
            PH_DATA:
            begin
                if (cmp_active)
                begin
                    matching_next = byte_ok;
                    pos_next      = pos_reg + 5'd1;
                    if (byte_ok && (pos_reg == 5'(UUID_BYTES - 1)))
                        latched_next = 1'b1;
                end
                left_next = left_dec;
                if (left_dec == 8'd0)
                    matching_next = 1'b0;
            end
            default:
            begin
                matching_next = 1'b0;
                pos_next      = '0;
                left_next     = ad_byte;
            end
        endcase
    end

    assign result.done  = step && last_byte;
    assign result.found = latched_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LENGTH;
            left_reg     <= '0;
            pos_reg      <= '0;
            matching_reg <= 1'b0;
            latched_reg  <= 1'b0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                phase_reg    <= PH_LENGTH;
                left_reg     <= '0;
                pos_reg      <= '0;
                matching_reg <= 1'b0;
                latched_reg  <= 1'b0;
            end
            else
            begin
                phase_reg    <= phase_next;
                left_reg     <= left_next;
                pos_reg      <= pos_next;
                matching_reg <= matching_next;
                latched_reg  <= latched_next;
            end
        end
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import auf_pkg::*;

    localparam int unsigned CLK_HALF     = 4;
    localparam int unsigned RESET_CYCLES = 6;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned PHASES       = 6;
    localparam int unsigned PHASE_WORDS  = 200;
    // long receiver hold-off starts once this many words have gone in
    localparam int unsigned HOLD_AT_WORD = 300;
    localparam int unsigned HOLD_CYCLES  = 200;
    // settling margin once every verdict is out
    localparam int unsigned DRAIN_CYCLES = 8;

    localparam logic [ADDR_W-1:0] ADDR_UUID_LOW  = {REG_UUID_LOW, 3'b000};
    localparam logic [ADDR_W-1:0] ADDR_UUID_HIGH = {REG_UUID_HIGH, 3'b000};

    typedef struct packed {
        logic [7:0] ad;
        logic       last;
    } ad_word_t;

    typedef enum int {
        FLD_EMPTY,
        FLD_UUID,
        FLD_SHORT_UUID,
        FLD_OTHER,
        FLD_NOISE
    } field_kind_t;

    // clock, reset and block ports
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [7:0]        ad_byte   = 8'h00;
    logic              last_byte = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              service_found;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [CFG_W-1:0]  pwdata    = '0;
    logic [CFG_W-1:0]  prdata;
    logic              pready;

    // words waiting to be offered, verdicts waiting to come out
    ad_word_t    word_q[$];
    logic        found_q[$];

    // predictor copy of the uuid registers and of the parse state
    logic [CFG_W-1:0] uuid_lo = '0;
    logic [CFG_W-1:0] uuid_hi = '0;
    auf_phase_t       phase   = PH_LENGTH;
    logic [7:0]       left    = 8'd0;
    logic [4:0]       upos    = 5'd0;
    logic             umatch  = 1'b0;
    logic             latched = 1'b0;

    // bookkeeping
    int unsigned queued_words   = 0;
    int unsigned accepted_words = 0;
    int unsigned cycle_count    = 0;
    int unsigned mismatches     = 0;
    logic        in_taken       = 1'b0;
    logic        calm           = 1'b0;
    int unsigned send_gap       = 0;
    int unsigned stall_left     = 0;
    int unsigned hold_left      = 0;
    logic        hold_done      = 1'b0;
    ad_word_t    next_word;

    advertising_service_uuid_finder_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .ad_byte       (ad_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .service_found (service_found),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // uuid byte k as sent on air, from the predictor's register copy
    function automatic logic [7:0] uuid_byte(input logic [4:0] k);
        logic [CFG_W-1:0] w;
        w = (k < 5'd8) ? uuid_lo : uuid_hi;
        return w[{k[2:0], 3'b000} +: 8];
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("tb_top: %s (cycle %0d)", what, cycle_count);
    endtask

    // walks one accepted word through the length-type-data parse
    task automatic parse_word(input logic [7:0] b, input logic last);
        case (phase)
            PH_TYPE:
            begin
                left   = left - 8'd1;
                upos   = 5'd0;
                umatch = (b == TYPE_PARTIAL_128 || b == TYPE_COMPLETE_128) &&
                         (left >= UUID_BYTES);
                phase  = (left == 8'd0) ? PH_LENGTH : PH_DATA;
            end
            PH_DATA:
            begin
                // only the first sixteen data bytes are compared
                if (umatch && upos < UUID_BYTES)
                begin
                    if (b != uuid_byte(upos))
                        umatch = 1'b0;
                    upos = upos + 5'd1;
                    if (umatch && upos == UUID_BYTES)
                        latched = 1'b1;
                end
                left = left - 8'd1;
                if (left == 8'd0)
                begin
                    phase  = PH_LENGTH;
                    umatch = 1'b0;
                end
            end
            default:
            begin
                // length byte; zero means an empty field with no type byte
                umatch = 1'b0;
                upos   = 5'd0;
                if (b == 8'd0)
                begin
                    phase = PH_LENGTH;
                    left  = 8'd0;
                end
                else
                begin
                    left  = b;
                    phase = PH_TYPE;
                end
            end
        endcase
        if (last)
        begin
            found_q.push_back(latched);
            phase   = PH_LENGTH;
            left    = 8'd0;
            upos    = 5'd0;
            umatch  = 1'b0;
            latched = 1'b0;
        end
    endtask

    task automatic push_word(input logic [7:0] b, input logic last);
        ad_word_t w;
        w.ad   = b;
        w.last = last;
        word_q.push_back(w);
        queued_words++;
    endtask

    // one payload of random fields, most of them well formed
    task automatic queue_payload();
        logic [7:0]  bq[$];
        logic [7:0]  typ;
        logic [7:0]  b;
        int          nfields;
        int          f;
        int          k;
        int          len;
        int          bad;
        int          cut;
        field_kind_t kind;
        int          r;
        nfields = $urandom_range(1, 4);
        for (f = 0; f < nfields; f++)
        begin
            r = $urandom_range(0, 15);
            if (r < 2)
                kind = FLD_EMPTY;
            else if (r < 9)
                kind = FLD_UUID;
            else if (r < 11)
                kind = FLD_SHORT_UUID;
            else if (r < 14)
                kind = FLD_OTHER;
            else
                kind = FLD_NOISE;
            typ = $urandom_range(0, 1) ? TYPE_PARTIAL_128 : TYPE_COMPLETE_128;
            case (kind)
                FLD_EMPTY:
                    bq.push_back(8'h00);
                FLD_UUID:
                begin
                    // a rare long field reaches the top of the length range
                    len = ($urandom_range(0, 31) == 0) ? $urandom_range(17, 255)
                                                       : $urandom_range(17, 20);
                    bad = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : -1;
                    bq.push_back(len[7:0]);
                    bq.push_back(typ);
                    for (k = 0; k < UUID_BYTES; k++)
                    begin
                        b = uuid_byte(k[4:0]);
                        if (k == bad)
                            b = b ^ 8'($urandom_range(1, 255));
                        bq.push_back(b);
                    end
                    for (k = UUID_BYTES; k < len - 1; k++)
                        bq.push_back(8'($urandom_range(0, 255)));
                end
                FLD_SHORT_UUID:
                begin
                    // length below 17 never matches, even with the right bytes
                    len = $urandom_range(1, 16);
                    bq.push_back(len[7:0]);
                    bq.push_back(typ);
                    for (k = 0; k < len - 1; k++)
                        bq.push_back(uuid_byte(k[4:0]));
                end
                FLD_OTHER:
                begin
                    len = $urandom_range(1, 8);
                    bq.push_back(len[7:0]);
                    for (k = 0; k < len; k++)
                        bq.push_back(8'($urandom_range(0, 255)));
                end
                default:
                begin
                    len = $urandom_range(1, 3);
                    for (k = 0; k < len; k++)
                        bq.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
        // some payloads end inside a field
        if ($urandom_range(0, 3) == 0)
        begin
            cut = $urandom_range(1, bq.size());
            while (bq.size() > cut)
                void'(bq.pop_back());
        end
        for (k = 0; k < bq.size(); k++)
            push_word(bq[k], k == bq.size() - 1);
    endtask

    // short directed opening, with the registers still at reset
    task automatic queue_directed();
        int k;
        // empty field, then a complete list of exactly one matching uuid
        push_word(8'h00, 1'b0);
        push_word(8'h11, 1'b0);
        push_word(TYPE_COMPLETE_128, 1'b0);
        for (k = 0; k < UUID_BYTES; k++)
            push_word(uuid_byte(k[4:0]), k == UUID_BYTES - 1);
        // top length byte that is also the last word
        push_word(8'hFF, 1'b1);
        // zero length byte alone
        push_word(8'h00, 1'b1);
        // short partial list ending inside the field
        push_word(8'h02, 1'b0);
        push_word(TYPE_PARTIAL_128, 1'b0);
        push_word(uuid_byte(5'd0), 1'b1);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_uuid(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
        apb_write(ADDR_UUID_LOW, lo);
        apb_write(ADDR_UUID_HIGH, hi);
        uuid_lo = lo;
        uuid_hi = hi;
    endtask

    // sender holds back until every word is in and every verdict is out
    task automatic wait_drained();
        @(negedge clk);
        while (accepted_words != queued_words || found_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [CFG_W-1:0] rand64();
        return {32'($urandom), 32'($urandom)};
    endfunction

    // sender: a stalled word stays put, gaps come in random bursts
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (word_q.size() != 0)
            begin
                next_word = word_q.pop_front();
                ad_byte   <= next_word.ad;
                last_byte <= next_word.last;
                in_valid  <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0)
                    send_gap = $urandom_range(1, 7);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stall bursts, and one long hold-off so the block fills up
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (!hold_done && accepted_words >= HOLD_AT_WORD)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (calm)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 6);
        end
        else
            out_stall <= 1'b0;
    end

    // monitor: both handshakes sampled at the rising edge
    always @(posedge clk)
    begin
        in_taken = 1'b0;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (found_q.size() == 0)
                    report_mismatch($sformatf("verdict %0b with none expected",
                                              service_found));
                else if (service_found !== found_q[0])
                begin
                    report_mismatch($sformatf("service_found %0b, expected %0b",
                                              service_found, found_q[0]));
                    void'(found_q.pop_front());
                end
                else
                    void'(found_q.pop_front());
            end
            if (in_valid && !in_stall)
            begin
                in_taken = 1'b1;
                accepted_words++;
                parse_word(ad_byte, last_byte);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("advertising_service_uuid_finder_top: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned ph;
        int unsigned target;
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (ph = 0; ph < PHASES; ph++)
        begin
            // registers change only with the block idle
            if (ph > 0)
            begin
                wait_drained();
                case (ph)
                    1:       set_uuid({CFG_W{1'b1}}, {CFG_W{1'b1}});
                    3:       set_uuid('0, rand64());
                    default: set_uuid(rand64(), rand64());
                endcase
            end
            // no idling in the last phase
            if (ph == PHASES - 1)
                calm = 1'b1;
            if (ph == 0)
                queue_directed();
            target = queued_words + PHASE_WORDS;
            while (queued_words < target)
                queue_payload();
        end

        wait_drained();
        if (mismatches == 0)
            $display("advertising_service_uuid_finder_top: match");
        else
            $display("advertising_service_uuid_finder_top: mismatch");
        $finish;
    end

endmodule
